>>> src/char_lcd_nibble_writer_assert.svh
// Assertion macros for the character LCD nibble writer.
// Used by the top level only; expects signals clock and reset in scope.
`ifndef CHAR_LCD_NIBBLE_WRITER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CNW_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define CNW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/cnw_pkg.sv
// Shared types, constants and tables of the character LCD nibble writer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cnw_pkg;

   localparam int JQ_DEPTH   = 4;
   localparam int JQ_PTR_W   = $clog2(JQ_DEPTH);
   localparam int JQ_COUNT_W = $clog2(JQ_DEPTH + 1);

   localparam logic [13:0] BUSY_US    = 14'd37;
   localparam logic [3:0]  INIT_LAST  = 4'd13;
   localparam logic [7:0]  CMD_CLEAR  = 8'h01;
   localparam logic [7:0]  CMD_CUR_ON = 8'h0E;
   localparam logic [7:0]  CMD_CUR_OFF = 8'h0C;
   localparam logic [2:0]  MAX_LINES  = 3'd4;

   typedef enum logic [2:0] {
      FUNC_PUTCHAR    = 3'd0,
      FUNC_LOCATE     = 3'd1,
      FUNC_CLEAR      = 3'd2,
      FUNC_CURSOR_ON  = 3'd3,
      FUNC_CURSOR_OFF = 3'd4,
      FUNC_INIT       = 3'd5,
      FUNC_CGRAM_SLOT = 3'd6,
      FUNC_GLYPH_ROW  = 3'd7
   } func_type;

   typedef enum logic {
      CSR_LINE_LENGTH = 1'b0,
      CSR_LINE_COUNT  = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      JOB_ONE_BYTE  = 2'd0,
      JOB_TWO_BYTES = 2'd1,
      JOB_INIT      = 2'd2
   } job_kind_type;

   typedef struct packed {
      func_type   func;
      logic [7:0] char_code;
      logic [7:0] column;
      logic [7:0] row;
      logic [2:0] slot;
   } req_type;

   typedef struct packed {
      logic        reg_select;
      logic [3:0]  nibble;
      logic [13:0] wait_us;
      logic        last;
   } rsp_type;

   typedef struct packed {
      job_kind_type kind;
      logic         rs0;
      logic [7:0]   byte0;
      logic         rs1;
      logic [7:0]   byte1;
   } job_type;

   typedef struct packed {
      logic [4:0] col;
      logic [1:0] row;
   } cursor_type;

   typedef struct packed {
      logic full;
      logic valid;
   } jq_status_type;

   typedef struct packed {
      logic [3:0]  nibble;
      logic [13:0] wait_us;
   } init_step_type;

   // Display address of the first character of each line.
   function automatic logic [6:0] line_base(input logic [1:0] line);
      logic [6:0] base;
      unique case (line)
         2'd0: base = 7'h00;
         2'd1: base = 7'h40;
         2'd2: base = 7'h14;
         2'd3: base = 7'h54;
         default: base = 7'h00;
      endcase
      return base;
   endfunction

   // Power-on sequence: four single nibbles, then five bytes high nibble first.
   function automatic init_step_type init_step(input logic [3:0] step);
      init_step_type s;
      unique case (step)
         4'd0:  s = '{nibble: 4'h3, wait_us: 14'd15000};
         4'd1:  s = '{nibble: 4'h3, wait_us: 14'd5000};
         4'd2:  s = '{nibble: 4'h3, wait_us: 14'd150};
         4'd3:  s = '{nibble: 4'h2, wait_us: 14'd150};
         4'd4:  s = '{nibble: 4'h2, wait_us: 14'd150};
         4'd5:  s = '{nibble: 4'h8, wait_us: 14'd0};
         4'd6:  s = '{nibble: 4'h0, wait_us: 14'd50};
         4'd7:  s = '{nibble: 4'h8, wait_us: 14'd0};
         4'd8:  s = '{nibble: 4'h0, wait_us: 14'd50};
         4'd9:  s = '{nibble: 4'h1, wait_us: 14'd0};
         4'd10: s = '{nibble: 4'h0, wait_us: 14'd2000};
         4'd11: s = '{nibble: 4'h6, wait_us: 14'd0};
         4'd12: s = '{nibble: 4'h0, wait_us: 14'd50};
         4'd13: s = '{nibble: 4'hC, wait_us: 14'd0};
         default: s = '{nibble: 4'h0, wait_us: 14'd0};
      endcase
      return s;
   endfunction

endpackage

>>> src/cnw_front.sv
// Front end: holds the line geometry registers and the text cursor, and turns
// each command but locate into a byte or init job for the back end. Depends on cnw_pkg.
`timescale 1ns / 1ps

module cnw_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  cnw_pkg::req_type       req,
   input  logic                   csr_write,
   input  logic                   csr_index,
   input  logic [4:0]             csr_wdata,
   output logic                   job_push,
   output cnw_pkg::job_type       job,
   output cnw_pkg::cursor_type    cursor
);
   import cnw_pkg::*;

   logic [4:0] line_length_ff, line_length_in;
   logic [2:0] line_count_ff, line_count_in;
   logic [4:0] col_ff, col_in;
   logic [1:0] row_ff, row_in;

   logic [2:0] eff_lines;
   logic [4:0] col_plus;
   logic [2:0] row_plus;
   logic [6:0] addr_sum;
   logic [7:0] cursor_cmd;
   logic       has_job;

   assign eff_lines  = (line_count_ff > MAX_LINES) ? MAX_LINES : line_count_ff;
   assign col_plus   = col_ff + 5'd1;
   assign row_plus   = {1'b0, row_ff} + 3'd1;
   assign addr_sum   = line_base(row_ff) + {2'b00, col_ff};
   assign cursor_cmd = {1'b1, addr_sum};

   always_comb begin
      line_length_in = line_length_ff;
      line_count_in  = line_count_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_LINE_LENGTH: line_length_in = csr_wdata;
            CSR_LINE_COUNT:  line_count_in  = csr_wdata[2:0];
            default:         line_length_in = line_length_ff;
         endcase
      end
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      has_job = 1'b1;
      job     = '{kind: JOB_ONE_BYTE, rs0: 1'b0, byte0: 8'h00, rs1: 1'b0, byte1: 8'h00};
      unique case (req.func)
         FUNC_PUTCHAR: begin
            job = '{kind: JOB_TWO_BYTES, rs0: 1'b0, byte0: cursor_cmd,
                    rs1: 1'b1, byte1: req.char_code};
            if (col_plus >= line_length_ff) begin
               col_in = 5'd0;
               // Row wraps to the top once it reaches the usable line count.
               row_in = (row_plus >= eff_lines) ? 2'd0 : row_plus[1:0];
            end else begin
               col_in = col_plus;
            end
         end
         FUNC_LOCATE: begin
            has_job = 1'b0;
            if (req.column < {3'b000, line_length_ff} && req.row < {5'b00000, eff_lines}) begin
               col_in = req.column[4:0];
               row_in = req.row[1:0];
            end
         end
         FUNC_CLEAR: begin
            job.byte0 = CMD_CLEAR;
            col_in    = 5'd0;
            row_in    = 2'd0;
         end
         FUNC_CURSOR_ON: begin
            job = '{kind: JOB_TWO_BYTES, rs0: 1'b0, byte0: 8'h80,
                    rs1: 1'b0, byte1: CMD_CUR_ON};
            job.byte0 = cursor_cmd;
         end
         FUNC_CURSOR_OFF: begin
            job.byte0 = CMD_CUR_OFF;
         end
         FUNC_INIT: begin
            job.kind = JOB_INIT;
            col_in   = 5'd0;
            row_in   = 2'd0;
         end
         FUNC_CGRAM_SLOT: begin
            job.byte0 = {2'b01, req.slot, 3'b000};
         end
         FUNC_GLYPH_ROW: begin
            job.rs0   = 1'b1;
            job.byte0 = req.char_code;
         end
         default: has_job = 1'b0;
      endcase
   end

   assign job_push = accept && has_job;
   assign cursor   = '{col: col_ff, row: row_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= 5'd20;
         line_count_ff  <= 3'd4;
         col_ff         <= 5'd0;
         row_ff         <= 2'd0;
      end else begin
         line_length_ff <= line_length_in;
         line_count_ff  <= line_count_in;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

endmodule

>>> src/cnw_job_queue.sv
// Small job queue between the front end and the nibble sequencer.
// Depends on cnw_pkg.
`timescale 1ns / 1ps

module cnw_job_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  cnw_pkg::job_type         job_in,
   input  logic                     pop,
   output cnw_pkg::jq_status_type   status,
   output cnw_pkg::job_type         job_out
);
   import cnw_pkg::*;

   job_type                 entry_ff [JQ_DEPTH];
   logic [JQ_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [JQ_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [JQ_COUNT_W-1:0]   count_ff, count_in;
   logic                    do_push, do_pop;

   assign status.full  = (count_ff == JQ_COUNT_W'(JQ_DEPTH));
   assign status.valid = (count_ff != '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && status.valid;
   assign job_out      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      priority if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)     count_in = count_ff - 1'b1;
      else                             count_in = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

>>> src/cnw_back.sv
// Back end: steps through the nibbles of the job at the queue head and holds
// one finished nibble in the result register. Depends on cnw_pkg.
`timescale 1ns / 1ps

module cnw_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  cnw_pkg::job_type   job,
   output logic               job_pop,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output cnw_pkg::rsp_type   rsp_data
);
   import cnw_pkg::*;

   logic [3:0]    step_ff, step_in;
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_ff, out_in;
   logic [3:0]    last_step;
   logic          is_last;
   logic          advance;
   logic [7:0]    cur_byte;
   init_step_type init_s;

   assign init_s   = init_step(step_ff);
   assign cur_byte = step_ff[1] ? job.byte1 : job.byte0;

   always_comb begin
      unique case (job.kind)
         JOB_ONE_BYTE:  last_step = 4'd1;
         JOB_TWO_BYTES: last_step = 4'd3;
         JOB_INIT:      last_step = INIT_LAST;
         default:       last_step = 4'd1;
      endcase
   end

   assign is_last = (step_ff == last_step);
   // A nibble moves into the result register when it is free or being drained.
   assign advance = job_valid && (!out_valid_ff || rsp_pop);
   assign job_pop = advance && is_last;

   always_comb begin
      out_in = out_ff;
      if (advance) begin
         if (job.kind == JOB_INIT) begin
            out_in.reg_select = 1'b0;
            out_in.nibble     = init_s.nibble;
            out_in.wait_us    = init_s.wait_us;
         end else begin
            out_in.reg_select = step_ff[1] ? job.rs1 : job.rs0;
            out_in.nibble     = step_ff[0] ? cur_byte[3:0] : cur_byte[7:4];
            out_in.wait_us    = step_ff[0] ? 14'd0 : BUSY_US;
         end
         out_in.last = is_last;
      end
      step_in = advance ? (is_last ? 4'd0 : step_ff + 4'd1) : step_ff;
      priority if (advance)  out_valid_in = 1'b1;
      else if (rsp_pop)      out_valid_in = 1'b0;
      else                   out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

>>> src/char_lcd_nibble_writer.sv
// Character LCD nibble writer. Each command beat becomes a burst of 4-bit bus
// transfers: a put character gives four nibbles, cursor on four, clear, cursor
// off, CGRAM slot and glyph row two each, init fourteen, and locate none. The
// back end sends one nibble per clock as long as the result side is drained;
// the front end takes one command per clock as long as its four-entry job
// queue has room, so full rises once the queued jobs outrun the result side.
// Once its command is accepted, the first nibble of a job passes through the
// job queue and then the result register to the result ports. Line geometry
// registers may be written only while the block idles.
`timescale 1ns / 1ps

module char_lcd_nibble_writer (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  cnw_pkg::req_type   req_data,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output cnw_pkg::rsp_type   rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [4:0]         csr_wdata
);
   import cnw_pkg::*;

`include "char_lcd_nibble_writer_assert.svh"

   logic          req_accept;
   logic          job_push;
   logic          job_pop;
   job_type       front_job;
   job_type       head_job;
   jq_status_type jq_status;
   cursor_type    cursor;
   logic          home_cmd;
   logic          cursor_home;
   logic          data_beat;
   logic          short_wait;

   assign csr_ready  = 1'b1;
   assign req_full   = jq_status.full;
   assign req_accept = req_push && !req_full;

   cnw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .req       (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .job_push  (job_push),
      .job       (front_job),
      .cursor    (cursor)
   );

   cnw_job_queue u_job_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (job_push),
      .job_in  (front_job),
      .pop     (job_pop),
      .status  (jq_status),
      .job_out (head_job)
   );

   cnw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (jq_status.valid),
      .job       (head_job),
      .job_pop   (job_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

   assign home_cmd    = req_accept &&
                        (req_data.func == FUNC_CLEAR || req_data.func == FUNC_INIT);
   assign cursor_home = (cursor.col == 5'd0) && (cursor.row == 2'd0);
   assign data_beat   = !rsp_empty && rsp_data.reg_select;
   assign short_wait  = (rsp_data.wait_us == BUSY_US) || (rsp_data.wait_us == 14'd0);

   `CNW_ASSERT_NEXT(a_clear_homes_cursor, home_cmd, cursor_home, "cursor not homed")
   `CNW_ASSERT_NOW(a_no_push_when_full, job_push, !jq_status.full, "push into a full queue")
   `CNW_ASSERT_NOW(a_data_wait_bounded, data_beat, short_wait, "data nibble with an init wait")

endmodule
